@@ design/gdd_pkg.sv @@
// Shared types, constants and calendar functions for the date difference unit.
package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 24;

  localparam int unsigned YEAR_MAX_DEF = 9999;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Divisibility by 25 through the modular inverse of 25 modulo 2**YEAR_W.
  localparam logic [YEAR_W-1:0] INV25   = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_T = 14'd655;

  // Packed with the year on top, so an unsigned compare orders dates.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic  ok;
    date_t next;
  } day_res_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div25;
    p     = y * INV25;
    div25 = (p <= DIV25_T);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ design/gdd_day_unit.sv @@
// Shared calendar unit: checks a date and gives the following day.
module gdd_day_unit #(
  parameter int unsigned YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
  input  gdd_pkg::date_t    date_i,
  output gdd_pkg::day_res_t res_o
);
  import gdd_pkg::*;

  localparam logic [16:0] YMAX = 17'(YEAR_MAX);

  logic             leap;
  logic [DAY_W-1:0] len;
  logic             month_ok;
  logic             year_ok;

  assign leap     = is_leap(date_i.year);
  assign len      = month_len(date_i.month, leap);
  assign month_ok = (date_i.month != '0) && (date_i.month <= MONTH_DEC);
  assign year_ok  = (date_i.year != '0) && ({3'b000, date_i.year} <= YMAX);

  always_comb begin
    res_o.ok   = month_ok && year_ok && (date_i.day != '0) && (date_i.day <= len);
    res_o.next = date_i;
    if (date_i.day < len) begin
      res_o.next.day = date_i.day + 5'd1;
    end else begin
      // roll over the month end, and the year after December
      res_o.next.day = 5'd1;
      if (date_i.month == MONTH_DEC) begin
        res_o.next.month = 4'd1;
        res_o.next.year  = date_i.year + 14'd1;
      end else begin
        res_o.next.month = date_i.month + 4'd1;
      end
    end
  end

endmodule

@@ design/gregorian_date_difference_unit.sv @@
// Sequence: IDLE accepts an item, CHK_A and CHK_B check both dates in turn on the shared
// day unit, WALK steps the earlier date forward one day at a time and counts until it meets
// the later date, and FINISH loads the output register; an invalid date skips WALK.
// Days walked is |difference| without the end day. FINISH waits while the output stalls;
// the input is ready only when idle, so a new item is taken only once the last left FINISH.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any result.
module gregorian_date_difference_unit #(
  parameter int unsigned YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year, zero pad
  input  logic [gdd_pkg::IN_W-1:0]  s_axis_tdata,
  // include_end_day
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // day_difference, zero pad
  output logic [gdd_pkg::OUT_W-1:0] m_axis_tdata,
  // date_invalid
  output logic                      m_axis_tuser
);
  import gdd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHK_A  = 5'b00010,
    ST_CHK_B  = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  localparam logic [DIFF_W-1:0] CNT_SAT = {1'b1, {(DIFF_W-1){1'b0}}};
  localparam logic [DIFF_W-1:0] POS_MAX = {1'b0, {(DIFF_W-1){1'b1}}};

  state_e            state_q, state_d;
  date_t             a_q, a_d;
  date_t             b_q, b_d;
  logic              inc_q, inc_d;
  logic              ok_a_q, ok_a_d;
  logic              neg_q, neg_d;
  logic              inv_q, inv_d;
  logic [DIFF_W-1:0] cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [DIFF_W-1:0] out_diff_q, out_diff_d;
  logic              out_inv_q, out_inv_d;

  date_t             unit_in;
  day_res_t          unit_res;
  logic              out_free;
  logic [DIFF_W-1:0] result;

  gdd_day_unit #(
    .YEAR_MAX(YEAR_MAX)
  ) u_day (
    .date_i(unit_in),
    .res_o (unit_res)
  );

  // a_q is the first date until ordering, then the walking cursor; b_q the target
  assign unit_in = (state_q == ST_CHK_B) ? b_q : a_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    if (inv_q) begin
      result = '0;
    end else if (neg_q) begin
      result = DIFF_W'(0) - cnt_q;
    end else if (cnt_q == CNT_SAT) begin
      result = POS_MAX;
    end else begin
      result = cnt_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    inc_d      = inc_q;
    ok_a_d     = ok_a_q;
    neg_d      = neg_q;
    inv_d      = inv_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_diff_d = out_diff_q;
    out_inv_d  = out_inv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          a_d.day    = s_axis_tdata[4:0];
          a_d.month  = s_axis_tdata[8:5];
          a_d.year   = s_axis_tdata[22:9];
          b_d.day    = s_axis_tdata[27:23];
          b_d.month  = s_axis_tdata[31:28];
          b_d.year   = s_axis_tdata[45:32];
          inc_d      = s_axis_tuser;
          state_d    = ST_CHK_A;
        end
      end
      ST_CHK_A: begin
        ok_a_d  = unit_res.ok;
        state_d = ST_CHK_B;
      end
      ST_CHK_B: begin
        inv_d = !(ok_a_q && unit_res.ok);
        neg_d = 1'b0;
        cnt_d = {{(DIFF_W-1){1'b0}}, inc_q};
        if (!(ok_a_q && unit_res.ok)) begin
          state_d = ST_FINISH;
        end else begin
          // walk forward from the earlier date
          if (a_q > b_q) begin
            a_d   = b_q;
            b_d   = a_q;
            neg_d = 1'b1;
          end
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (a_q == b_q || cnt_q == CNT_SAT) begin
          state_d = ST_FINISH;
        end else begin
          a_d   = unit_res.next;
          cnt_d = cnt_q + DIFF_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_diff_d = result;
          out_inv_d  = inv_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    inc_q      <= inc_d;
    ok_a_q     <= ok_a_d;
    neg_q      <= neg_d;
    inv_q      <= inv_d;
    cnt_q      <= cnt_d;
    out_diff_q <= out_diff_d;
    out_inv_q  <= out_inv_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_W-DIFF_W){1'b0}}, out_diff_q};
  assign m_axis_tuser  = out_inv_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> a_q <= b_q)
    else $error("walking cursor passed the target date");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> cnt_q <= CNT_SAT)
    else $error("day count beyond saturation limit");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> out_diff_q == '0)
    else $error("invalid date with nonzero difference");

  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished item not loaded into output register");

endmodule

@@ tb/gregorian_date_difference_unit_tb.sv @@
// Testbench for the Gregorian date difference unit: queued stimulus, self-checking monitor.
`timescale 1ns / 1ps

module gregorian_date_difference_unit_tb;
  import gdd_pkg::*;

  localparam int unsigned YEAR_TOP    = YEAR_MAX_DEF;
  localparam longint      DIFF_HI     = (longint'(1) << (DIFF_W - 1)) - 1;
  localparam longint      DIFF_LO     = -(longint'(1) << (DIFF_W - 1));
  // Two full-range walks of about 3.65M days each dominate the run.
  localparam longint      CYCLE_LIMIT = 32_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 20;
  localparam int unsigned NUM_PHASES  = 4;

  typedef struct {
    logic [DAY_W-1:0]   d1;
    logic [MONTH_W-1:0] m1;
    logic [YEAR_W-1:0]  y1;
    logic [DAY_W-1:0]   d2;
    logic [MONTH_W-1:0] m2;
    logic [YEAR_W-1:0]  y2;
    logic               inc;
    bit                 settle_first;
  } date_pair_t;

  typedef struct {
    logic [DIFF_W-1:0] diff;
    logic              invalid;
  } day_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  date_pair_t  date_pairs[$];
  day_result_t expected_diffs[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  longint      cycle_count = 0;

  gregorian_date_difference_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m == MONTH_FEB) begin
      return leap_year(y) ? 29 : 28;
    end
    case (m)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_real(int unsigned d, int unsigned m, int unsigned y);
    if (m < 1 || m > MONTH_DEC || y < 1 || y > YEAR_TOP || d < 1) begin
      return 1'b0;
    end
    return d <= month_days(m, y);
  endfunction

  // Day count with 1 January of year 1 as day 1.
  function automatic longint serial_day(int unsigned d, int unsigned m, int unsigned y);
    longint      n;
    int unsigned p;
    p = y - 1;
    n = 365 * longint'(p) + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) begin
      n += month_days(k, y);
    end
    return n + d;
  endfunction

  function automatic day_result_t predict_day_difference(date_pair_t p);
    day_result_t r;
    longint      span;
    r.diff    = '0;
    r.invalid = 1'b1;
    if (!date_real(p.d1, p.m1, p.y1) || !date_real(p.d2, p.m2, p.y2)) begin
      return r;
    end
    span = serial_day(p.d2, p.m2, p.y2) - serial_day(p.d1, p.m1, p.y1);
    if (p.inc) begin
      span += (span < 0) ? -1 : 1;
    end
    if (span > DIFF_HI) begin
      span = DIFF_HI;
    end
    if (span < DIFF_LO) begin
      span = DIFF_LO;
    end
    r.diff    = span[DIFF_W-1:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  function automatic date_pair_t make_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                           int unsigned d2, int unsigned m2, int unsigned y2,
                                           bit inc);
    date_pair_t p;
    p.d1 = d1[DAY_W-1:0];
    p.m1 = m1[MONTH_W-1:0];
    p.y1 = y1[YEAR_W-1:0];
    p.d2 = d2[DAY_W-1:0];
    p.m2 = m2[MONTH_W-1:0];
    p.y2 = y2[YEAR_W-1:0];
    p.inc = inc;
    p.settle_first = 1'b0;
    return p;
  endfunction

  // Lean on century years and month ends, where the calendar rules bite.
  function automatic int unsigned pick_year();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(99, 1) * 100 + $urandom_range(2) * 4 - 4 + $urandom_range(1) * 4;
    end
    return $urandom_range(YEAR_TOP, 1);
  endfunction

  function automatic int unsigned pick_day(int unsigned m, int unsigned y);
    if ($urandom_range(9) < 3) begin
      return month_days(m, y);
    end
    return $urandom_range(month_days(m, y), 1);
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned kind;
    int unsigned d1, m1, y1, d2, m2, y2;
    int          shift;
    kind = $urandom_range(99);
    y1 = pick_year();
    if (y1 < 1 || y1 > YEAR_TOP) begin
      y1 = $urandom_range(YEAR_TOP, 1);
    end
    m1 = $urandom_range(MONTH_DEC, 1);
    d1 = pick_day(m1, y1);
    y2 = y1;
    m2 = m1;
    d2 = d1;
    if (kind >= 10) begin
      if (kind < 75) begin
        shift = $urandom_range(2) - 1;
      end else if (kind < 82) begin
        shift = $urandom_range(20) - 10;
      end else if (kind < 85) begin
        shift = $urandom_range(80) - 40;
      end else begin
        shift = 0;
      end
      if (int'(y1) + shift < 1 || int'(y1) + shift > int'(YEAR_TOP)) begin
        shift = -shift;
      end
      y2 = int'(y1) + shift;
      m2 = $urandom_range(MONTH_DEC, 1);
      d2 = pick_day(m2, y2);
    end
    if (kind >= 85) begin
      // Break the first date in one field.
      case ($urandom_range(3))
        0: d1 = (month_days(m1, y1) < 31) ? $urandom_range(31, month_days(m1, y1) + 1) : 0;
        1: d1 = 0;
        2: m1 = $urandom_range(1) ? 0 : $urandom_range(15, MONTH_DEC + 1);
        default: y1 = $urandom_range(1) ? 0 : $urandom_range(16383, YEAR_TOP + 1);
      endcase
    end
    if ($urandom_range(1)) begin
      p = make_pair(d2, m2, y2, d1, m1, y1, $urandom_range(1));
    end else begin
      p = make_pair(d1, m1, y1, d2, m2, y2, $urandom_range(1));
    end
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sample at the falling edge, once the rising-edge updates have all landed.
  task automatic wait_settled();
    while (date_pairs.size() != 0 || s_axis_tvalid || expected_diffs.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    date_pair_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_diffs.push_back(predict_day_difference(nxt));
      end
      // Hold the current item until it is taken.
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (date_pairs.size() != 0 &&
            !(date_pairs[0].settle_first && expected_diffs.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = date_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, nxt.y2, nxt.m2, nxt.d2, nxt.y1, nxt.m1, nxt.d1};
          s_axis_tuser  <= nxt.inc;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    day_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_diffs.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_diffs.pop_front();
          if (m_axis_tdata[DIFF_W-1:0] !== want.diff) begin
            report_mismatch($sformatf("day_difference got %0d want %0d",
                                      $signed(m_axis_tdata[DIFF_W-1:0]), $signed(want.diff)));
          end
          if (m_axis_tuser !== want.invalid) begin
            report_mismatch($sformatf("date_invalid got %b want %b",
                                      m_axis_tuser, want.invalid));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gregorian_date_difference_unit_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_pcts[NUM_PHASES];
    int unsigned recv_pcts[NUM_PHASES];
    date_pair_t  p;
    send_pcts = '{0, 87, 0, 18};
    recv_pcts = '{0, 0, 87, 18};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Equal dates, leap rules, year rollover, invalid fields on either side.
    date_pairs.push_back(make_pair(15, 6, 2024, 15, 6, 2024, 0));
    date_pairs.push_back(make_pair(15, 6, 2024, 15, 6, 2024, 1));
    date_pairs.push_back(make_pair(28, 2, 1900, 1, 3, 1900, 0));
    date_pairs.push_back(make_pair(28, 2, 2000, 1, 3, 2000, 1));
    date_pairs.push_back(make_pair(29, 2, 2000, 1, 3, 2000, 0));
    date_pairs.push_back(make_pair(29, 2, 1900, 1, 3, 1900, 0));
    date_pairs.push_back(make_pair(31, 12, 1999, 1, 1, 2000, 0));
    date_pairs.push_back(make_pair(1, 1, 2000, 31, 12, 1999, 1));
    date_pairs.push_back(make_pair(29, 2, 2024, 28, 2, 2028, 0));
    date_pairs.push_back(make_pair(31, 1, 2023, 28, 2, 2023, 1));
    date_pairs.push_back(make_pair(31, 4, 2021, 1, 5, 2021, 0));
    date_pairs.push_back(make_pair(0, 1, 2021, 1, 1, 2021, 0));
    date_pairs.push_back(make_pair(1, 0, 2021, 1, 1, 2021, 1));
    date_pairs.push_back(make_pair(1, 1, 2021, 5, 13, 2021, 0));
    date_pairs.push_back(make_pair(31, 15, 16383, 31, 15, 16383, 1));
    date_pairs.push_back(make_pair(1, 1, 0, 1, 1, 1, 0));
    date_pairs.push_back(make_pair(1, 1, 9999, 1, 1, 10000, 0));
    date_pairs.push_back(make_pair(1, 1, 1, 2, 1, 1, 0));
    date_pairs.push_back(make_pair(31, 12, 9999, 30, 12, 9999, 1));
    date_pairs.push_back(make_pair(30, 9, 8191, 31, 12, 8192, 0));
    // Widest spans in both directions.
    date_pairs.push_back(make_pair(1, 1, 1, 31, 12, 9999, 1));
    date_pairs.push_back(make_pair(31, 12, 9999, 1, 1, 1, 1));
    wait_settled();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        p = random_pair();
        // Now and then wait for the unit to drain before sending.
        p.settle_first = (n % 10 == 9);
        date_pairs.push_back(p);
      end
      wait_settled();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gregorian_date_difference_unit_tb: clean");
    end else begin
      $display("gregorian_date_difference_unit_tb: errors");
    end
    $finish;
  end

endmodule
